FILE: rtl/ias_accumulator_execute_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator execute unit
// Concurrent checks clocked on aclk; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef IAS_ACCUMULATOR_EXECUTE_UNIT_DEFINES_SVH
`define IAS_ACCUMULATOR_EXECUTE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check outside reset
`define IASACC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// check that also holds through reset
`define IASACC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define IASACC_ASSERT(lbl, prop, msg)
`define IASACC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: rtl/iasacc_pkg.sv
// ----------------------------------------------------------------------------
// iasacc_pkg
// Widths, opcodes, word types and control types of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package iasacc_pkg;

    localparam int ADDR_W = 10;
    localparam int WORD_W = 32;
    localparam int OP_W   = 5;
    localparam int CNT_W  = $clog2(WORD_W);

    localparam logic [OP_W-1:0] OP_NOP      = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD_MQ  = 5'd1;
    localparam logic [OP_W-1:0] OP_LDMQ_M   = 5'd2;
    localparam logic [OP_W-1:0] OP_STOR     = 5'd3;
    localparam logic [OP_W-1:0] OP_LOAD     = 5'd4;
    localparam logic [OP_W-1:0] OP_LOAD_NEG = 5'd5;
    localparam logic [OP_W-1:0] OP_LOAD_ABS = 5'd6;
    localparam logic [OP_W-1:0] OP_LOAD_NAB = 5'd7;
    localparam logic [OP_W-1:0] OP_JUMP     = 5'd8;
    localparam logic [OP_W-1:0] OP_JUMP_POS = 5'd9;
    localparam logic [OP_W-1:0] OP_ADD      = 5'd10;
    localparam logic [OP_W-1:0] OP_ADD_ABS  = 5'd11;
    localparam logic [OP_W-1:0] OP_SUB      = 5'd12;
    localparam logic [OP_W-1:0] OP_SUB_ABS  = 5'd13;
    localparam logic [OP_W-1:0] OP_MUL      = 5'd14;
    localparam logic [OP_W-1:0] OP_DIV      = 5'd15;
    localparam logic [OP_W-1:0] OP_LSH      = 5'd16;
    localparam logic [OP_W-1:0] OP_RSH      = 5'd17;
    localparam logic [OP_W-1:0] OP_BEGIN    = 5'd18;
    localparam logic [OP_W-1:0] OP_HALT     = 5'd19;

    typedef logic [WORD_W-1:0] word_t;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic [ADDR_W-1:0]        instruction_address;
        logic signed [WORD_W-1:0] operand_value;
    } iasacc_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0]        next_pc;
        logic signed [WORD_W-1:0] accumulator;
        logic signed [WORD_W-1:0] mq_register;
        logic                     store_enable;
        logic signed [WORD_W-1:0] store_data;
        logic                     halted;
        logic                     divide_error;
    } iasacc_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIX
    } iasacc_state_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic commit;
    } iasacc_cmd_t;

    typedef struct packed {
        logic div_op;
        logic div_last;
    } iasacc_sts_t;

    function automatic word_t neg_w(input word_t v);
        return ~v + word_t'(1);
    endfunction

    function automatic word_t abs_w(input word_t v);
        return v[WORD_W-1] ? neg_w(v) : v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ias_accumulator_execute_unit.sv
// ----------------------------------------------------------------------------
// ias_accumulator_execute_unit - execute unit of an IAS-style accumulator machine
// The result word is registered; a divide runs the 32-step divider, then a sign fix-up.
// A new word is taken only in idle, once the previous word has committed its result.
// Reset (aresetn low, synchronous): PC, AC, MQ, started and halted cleared, no result held.
// ----------------------------------------------------------------------------
`default_nettype none

module ias_accumulator_execute_unit (
    input  wire                       aclk,
    input  wire                       aresetn,
    // instruction word in
    input  wire                       s_valid,
    output logic                      s_ready,
    input  iasacc_pkg::iasacc_in_t    s_payload,
    // result word out
    output logic                      m_valid,
    input  wire                       m_ready,
    output iasacc_pkg::iasacc_out_t   m_payload
);
    import iasacc_pkg::*;

    // The sequencer accepts one word at a time, in its idle state. The result
    // register parts the two sides: a new word is taken while the previous
    // result still waits on m_ready, and only the commit of the next result
    // waits for the slot to drain.
    iasacc_cmd_t cmd;
    iasacc_sts_t sts;

    // Sequencer: idle -> execute -> (divide steps -> fix-up) -> commit.
    iasacc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Datapath: architectural state, ALU with one multiplier, restoring
    // divider on magnitudes with sign fix-up, and the result register.
    iasacc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_payload (s_payload),
        .m_payload (m_payload),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

FILE: rtl/iasacc_ctrl.sv
// ----------------------------------------------------------------------------
// iasacc_ctrl
// Sequencer: accepts a word, runs the divider when needed, commits the result.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ias_accumulator_execute_unit_defines.svh"

module iasacc_ctrl (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       s_valid,
    output logic                      s_ready,
    output logic                      m_valid,
    input  wire                       m_ready,
    output iasacc_pkg::iasacc_cmd_t   cmd,
    input  iasacc_pkg::iasacc_sts_t   sts
);
    import iasacc_pkg::*;

    iasacc_state_t state_reg, state_next;
    logic          m_valid_reg, m_valid_next;
    logic          slot_free;

    assign slot_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (sts.div_op)   state_next = ST_DIV;
                else if (slot_free) state_next = ST_IDLE;
            end
            ST_DIV: begin
                if (sts.div_last) state_next = ST_FIX;
            end
            ST_FIX: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_EXEC: begin
                cmd.div_init = sts.div_op;
                cmd.commit   = !sts.div_op && slot_free;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_FIX: begin
                cmd.commit = slot_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // hold the result word until taken; a commit refills the slot
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit)   m_valid_next = 1'b1;
        else if (m_ready) m_valid_next = 1'b0;
    end

    assign m_valid = m_valid_reg;

    `IASACC_ASSERT(a_commit_slot, cmd.commit |-> (!m_valid_reg || m_ready), "commit over a held word")
    `IASACC_ASSERT(a_div_enter, cmd.div_init |=> (state_reg == ST_DIV), "divider start lost")
    `IASACC_ASSERT_RST(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid_reg), "not idle after reset")

endmodule

`default_nettype wire

FILE: rtl/iasacc_datapath.sv
// ----------------------------------------------------------------------------
// iasacc_datapath
// Architectural registers, combinational ALU, radix-2 divider, result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ias_accumulator_execute_unit_defines.svh"

module iasacc_datapath (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  iasacc_pkg::iasacc_in_t    s_payload,
    output iasacc_pkg::iasacc_out_t   m_payload,
    input  iasacc_pkg::iasacc_cmd_t   cmd,
    output iasacc_pkg::iasacc_sts_t   sts
);
    import iasacc_pkg::*;

    iasacc_in_t        in_reg;
    iasacc_out_t       out_reg, out_next;
    logic [ADDR_W-1:0] pc_reg, pc_next;
    word_t             ac_reg, ac_next;
    word_t             mq_reg, mq_next;
    logic              started_reg, started_next;
    logic              stopped_reg, stopped_next;
    word_t             rem_reg, rem_next;
    word_t             quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    word_t             m_val, m_abs, prod, div_q, div_r;
    logic [OP_W-1:0]   opc;
    logic [WORD_W:0]   trial;
    logic              st_en, div_err;

    assign opc   = in_reg.opcode;
    assign m_val = word_t'(in_reg.operand_value);
    assign m_abs = abs_w(m_val);
    assign prod  = mq_reg * m_val;

    // divider: one quotient bit per step on magnitudes
    assign trial = {rem_reg, quo_reg[WORD_W-1]} - {1'b0, m_abs};
    assign div_q = (ac_reg[WORD_W-1] != m_val[WORD_W-1]) ? neg_w(quo_reg) : quo_reg;
    assign div_r = ac_reg[WORD_W-1] ? neg_w(rem_reg) : rem_reg;

    assign sts.div_op   = !stopped_reg && started_reg && (opc == OP_DIV) && (m_val != '0);
    assign sts.div_last = (cnt_reg == '0);

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_init) begin
            rem_next = '0;
            quo_next = abs_w(ac_reg);
            cnt_next = CNT_W'(WORD_W - 1);
        end else if (cmd.div_step) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (!trial[WORD_W]) begin
                rem_next = trial[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[WORD_W-2:0], quo_reg[WORD_W-1]};
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        pc_next      = pc_reg;
        ac_next      = ac_reg;
        mq_next      = mq_reg;
        started_next = started_reg;
        stopped_next = stopped_reg;
        st_en        = 1'b0;
        div_err      = 1'b0;
        if (!stopped_reg) begin
            pc_next = pc_reg + ADDR_W'(1);
            priority if (opc == OP_HALT) begin
                stopped_next = 1'b1;
            end else if (opc == OP_BEGIN) begin
                started_next = 1'b1;
            end else if (started_reg) begin
                unique case (opc)
                    OP_LOAD_MQ:  ac_next = mq_reg;
                    OP_LDMQ_M:   mq_next = m_val;
                    OP_STOR:     st_en = 1'b1;
                    OP_LOAD:     ac_next = m_val;
                    OP_LOAD_NEG: ac_next = neg_w(m_val);
                    OP_LOAD_ABS: ac_next = m_abs;
                    OP_LOAD_NAB: ac_next = neg_w(m_abs);
                    OP_JUMP:     pc_next = in_reg.instruction_address;
                    OP_JUMP_POS: begin
                        if (!ac_reg[WORD_W-1]) pc_next = in_reg.instruction_address;
                    end
                    OP_ADD:      ac_next = ac_reg + m_val;
                    OP_ADD_ABS:  ac_next = ac_reg + m_abs;
                    OP_SUB:      ac_next = ac_reg - m_val;
                    OP_SUB_ABS:  ac_next = ac_reg - m_abs;
                    OP_MUL:      ac_next = prod;
                    OP_DIV: begin
                        if (m_val == '0) begin
                            div_err = 1'b1;
                        end else begin
                            ac_next = div_r;
                            mq_next = div_q;
                        end
                    end
                    OP_LSH:      ac_next = {ac_reg[WORD_W-2:0], 1'b0};
                    OP_RSH:      ac_next = {ac_reg[WORD_W-1], ac_reg[WORD_W-1:1]};
                    default:     ac_next = ac_reg;
                endcase
            end else begin
                // not started yet: drop the operation, only PC advances
                st_en = 1'b0;
            end
        end
    end

    always_comb begin
        out_next.next_pc      = pc_next;
        out_next.accumulator  = ac_next;
        out_next.mq_register  = mq_next;
        out_next.store_enable = st_en;
        out_next.store_data   = ac_next;
        out_next.halted       = stopped_next;
        out_next.divide_error = div_err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= '0;
            ac_reg      <= '0;
            mq_reg      <= '0;
            started_reg <= 1'b0;
            stopped_reg <= 1'b0;
        end else if (cmd.commit) begin
            pc_reg      <= pc_next;
            ac_reg      <= ac_next;
            mq_reg      <= mq_next;
            started_reg <= started_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) in_reg <= s_payload;
        if (cmd.commit) out_reg <= out_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    assign m_payload = out_reg;

    `IASACC_ASSERT(a_halt_sticky, stopped_reg |=> stopped_reg, "halt released without reset")
    `IASACC_ASSERT(a_halt_quiet, (cmd.commit && stopped_reg) |=> (!out_reg.store_enable && out_reg.halted && !out_reg.divide_error), "halted unit produced activity")

endmodule

`default_nettype wire
